// ===== design/srrw_pkg.sv =====
// ----------------------------------------------------------------------------
// srrw_pkg: shared types and constants for the receive window
// Result kinds, beat layouts and the sequencer state encoding.
// ----------------------------------------------------------------------------
package srrw_pkg;

    // Field widths
    localparam int SEQ_W = 32;
    localparam int PAY_W = 32;
    localparam int LEN_W = 11;
    localparam int KIND_W = 2;

    // Beat widths: fields packed from bit 0 and padded to whole bytes
    localparam int S_DATA_W = 80;   // seq_num, payload, payload_len
    localparam int M_DATA_W = 80;   // seq, payload_res, payload_len_res, end_seen

    // Result kinds carried on m_tuser
    localparam logic [KIND_W-1:0] KIND_ACK = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DELIVER = 2'd1;
    localparam logic [KIND_W-1:0] KIND_IGNORE = 2'd2;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CLASS = 4'b0010,
        ST_READ  = 4'b0100,
        ST_DELIV = 4'b1000
    } state_t;

endpackage

// ===== design/selective_repeat_receive_window.sv =====
// ----------------------------------------------------------------------------
// selective_repeat_receive_window: receiver reorder window
// Acknowledges packets below the window end, stores in-window packets in
// their slot and delivers the contiguous run from the left edge in order.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake          Content
//  s_*       in         s_tvalid/s_tready  one packet per beat
//  m_*       out        m_tvalid/m_tready  ack, delivery or ignore result
//  cfg_*     in         cfg_valid/cfg_ready start sequence number
//
//  Steps: an ack-only or ignored packet is accepted, then classified;
//  each delivered packet adds a slot memory read, then its result.
//  A start_seq write is taken while idle, ahead of any packet;
//  s_tready stays low while cfg_valid is high.
//  Reset clears the edge, the received marks and the output stage; the slot
//  memory is not cleared. A result held by m_tready low stalls the sequencer.
//
module selective_repeat_receive_window #(
    parameter int WIN_LEN = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration write
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [srrw_pkg::SEQ_W-1:0]    cfg_data,
    // packet input
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [srrw_pkg::S_DATA_W-1:0] s_tdata,  // seq_num, payload, payload_len
    input  logic                          s_tlast,  // end_flag
    // results
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [srrw_pkg::M_DATA_W-1:0] m_tdata,  // seq, payload_res, payload_len_res,
                                                    // end_seen
    output logic [srrw_pkg::KIND_W-1:0]   m_tuser,  // kind
    output logic                          m_tlast   // last
);

    localparam int SW = (WIN_LEN > 1) ? $clog2(WIN_LEN) : 1;
    localparam int SEQ_W = srrw_pkg::SEQ_W;
    localparam int PAY_W = srrw_pkg::PAY_W;
    localparam int LEN_W = srrw_pkg::LEN_W;
    localparam int ENT_W = PAY_W + LEN_W;
    localparam logic [SW:0] WIN_W = (SW+1)'(WIN_LEN);

    // Control registers
    srrw_pkg::state_t state_reg, state_next;
    logic [SEQ_W-1:0]   left_edge_reg, left_edge_next;
    logic [SW-1:0]      edge_slot_reg, edge_slot_next;
    logic [WIN_LEN-1:0] recv_reg, recv_next;
    logic               m_valid_reg, m_valid_next;

    // Payload registers
    logic [SEQ_W-1:0]   seq_reg;
    logic [PAY_W-1:0]   pay_reg;
    logic [LEN_W-1:0]   len_reg;
    logic               end_reg;
    logic [srrw_pkg::KIND_W-1:0] m_kind_reg, m_kind_next;
    logic [SEQ_W-1:0]   m_seq_reg, m_seq_next;
    logic [PAY_W-1:0]   m_pay_reg, m_pay_next;
    logic [LEN_W-1:0]   m_len_reg, m_len_next;
    logic               m_end_reg, m_end_next;
    logic               m_last_reg, m_last_next;

    // Slot memory: {payload, length}
    logic [ENT_W-1:0]   slot_mem [WIN_LEN];
    logic [ENT_W-1:0]   rd_data_reg;
    logic               mem_we;
    logic               mem_re;

    // Datapath terms
    logic               load_item;
    logic               out_free;
    logic [SEQ_W:0]     diff;
    logic               below;
    logic               ignore;
    logic               in_win;
    logic               deliver_now;
    logic [SW:0]        slot_sum;
    logic [SW-1:0]      wr_slot;
    logic [SW:0]        edge_inc;
    logic [SW-1:0]      next_slot;
    logic               at_max;
    logic               more;

    assign out_free  = !m_valid_reg || m_tready;
    assign cfg_ready = (state_reg == srrw_pkg::ST_IDLE);
    assign s_tready  = (state_reg == srrw_pkg::ST_IDLE) && !cfg_valid;
    assign load_item = s_tvalid && s_tready;

    // Classify against the window: one wide subtract and a compare
    assign diff   = {1'b0, seq_reg} - {1'b0, left_edge_reg};
    assign below  = diff[SEQ_W];
    assign ignore = !below && (diff[SEQ_W-1:0] >= SEQ_W'(WIN_LEN));
    assign in_win = !below && !ignore;
    assign deliver_now = in_win && (diff[SEQ_W-1:0] == '0);

    // Slot of the packet: edge slot plus offset, wrapped once
    assign slot_sum = {1'b0, edge_slot_reg} + {1'b0, diff[SW-1:0]};
    assign wr_slot  = (slot_sum >= WIN_W) ? SW'(slot_sum - WIN_W) : slot_sum[SW-1:0];

    // Next edge slot and run continuation
    assign edge_inc  = {1'b0, edge_slot_reg} + (SW+1)'(1);
    assign next_slot = (edge_inc == WIN_W) ? '0 : edge_inc[SW-1:0];
    assign at_max    = (left_edge_reg == '1);
    assign more      = !at_max && recv_reg[next_slot];

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        left_edge_next = left_edge_reg;
        edge_slot_next = edge_slot_reg;
        recv_next      = recv_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_kind_next    = m_kind_reg;
        m_seq_next     = m_seq_reg;
        m_pay_next     = m_pay_reg;
        m_len_next     = m_len_reg;
        m_end_next     = m_end_reg;
        m_last_next    = m_last_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        case (state_reg)
            srrw_pkg::ST_IDLE: begin
                if (cfg_valid) begin
                    // reload edge, drop marks, restart the slot map at slot 0
                    left_edge_next = cfg_data;
                    recv_next      = '0;
                    edge_slot_next = '0;
                end else if (load_item) begin
                    state_next = srrw_pkg::ST_CLASS;
                end
            end
            srrw_pkg::ST_CLASS: begin
                if (out_free) begin
                    // emit ack or ignore, store in-window packet
                    m_valid_next = 1'b1;
                    m_kind_next  = ignore ? srrw_pkg::KIND_IGNORE : srrw_pkg::KIND_ACK;
                    m_seq_next   = seq_reg;
                    m_pay_next   = '0;
                    m_len_next   = '0;
                    m_end_next   = end_reg;
                    m_last_next  = !deliver_now;
                    if (in_win) begin
                        mem_we             = 1'b1;
                        recv_next[wr_slot] = 1'b1;
                    end
                    state_next = deliver_now ? srrw_pkg::ST_READ : srrw_pkg::ST_IDLE;
                end
            end
            srrw_pkg::ST_READ: begin
                mem_re     = 1'b1;
                state_next = srrw_pkg::ST_DELIV;
            end
            srrw_pkg::ST_DELIV: begin
                if (out_free) begin
                    // deliver edge slot, clear it, advance edge
                    m_valid_next = 1'b1;
                    m_kind_next  = srrw_pkg::KIND_DELIVER;
                    m_seq_next   = left_edge_reg;
                    m_pay_next   = rd_data_reg[ENT_W-1:LEN_W];
                    m_len_next   = rd_data_reg[LEN_W-1:0];
                    m_end_next   = end_reg;
                    m_last_next  = !more;
                    recv_next[edge_slot_reg] = 1'b0;
                    if (!at_max) begin
                        left_edge_next = left_edge_reg + SEQ_W'(1);
                        edge_slot_next = next_slot;
                    end
                    state_next = more ? srrw_pkg::ST_READ : srrw_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = srrw_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= srrw_pkg::ST_IDLE;
            left_edge_reg <= '0;
            edge_slot_reg <= '0;
            recv_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            left_edge_reg <= left_edge_next;
            edge_slot_reg <= edge_slot_next;
            recv_reg      <= recv_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Item capture and output stage
    always_ff @(posedge aclk) begin
        if (load_item) begin
            seq_reg <= s_tdata[SEQ_W-1:0];
            pay_reg <= s_tdata[SEQ_W+PAY_W-1:SEQ_W];
            len_reg <= s_tdata[SEQ_W+PAY_W+LEN_W-1:SEQ_W+PAY_W];
            end_reg <= s_tlast;
        end
        m_kind_reg    <= m_kind_next;
        m_seq_reg     <= m_seq_next;
        m_pay_reg     <= m_pay_next;
        m_len_reg     <= m_len_next;
        m_end_reg     <= m_end_next;
        m_last_reg    <= m_last_next;
    end

    // Slot memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            slot_mem[wr_slot] <= {pay_reg, len_reg};
        end
        if (mem_re) begin
            rd_data_reg <= slot_mem[edge_slot_reg];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {{(srrw_pkg::M_DATA_W - SEQ_W - PAY_W - LEN_W - 1){1'b0}},
                       m_end_reg, m_len_reg, m_pay_reg, m_seq_reg};

endmodule

// ===== design/srrw_checker.sv =====
// ----------------------------------------------------------------------------
// srrw_checker: port-level checks for the receive window
// Watches the result channel for kind, payload and framing rules.
// ----------------------------------------------------------------------------
module srrw_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [srrw_pkg::M_DATA_W-1:0] m_tdata,
    input logic [srrw_pkg::KIND_W-1:0]   m_tuser,
    input logic                          m_tlast
);

    localparam int PAY_LO = srrw_pkg::SEQ_W;
    localparam int LEN_HI = srrw_pkg::SEQ_W + srrw_pkg::PAY_W + srrw_pkg::LEN_W - 1;

    // Hold a stalled result beat
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result beat changed");

    // An ignored packet yields exactly one result
    a_ignore_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == srrw_pkg::KIND_IGNORE) |-> m_tlast)
        else $error("ignore result not marked last");

    // Only deliveries carry payload and length
    a_zero_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != srrw_pkg::KIND_DELIVER) |-> m_tdata[LEN_HI:PAY_LO] == '0)
        else $error("non-delivery result carries payload");

    // After a result beat not marked last, a delivery is the only kind allowed next
    a_deliver_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast ##1 m_tvalid |->
            (m_tuser == srrw_pkg::KIND_DELIVER))
        else $error("delivery run broken by another kind");

endmodule

bind selective_repeat_receive_window srrw_checker u_srrw_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for the selective-repeat receive window
// Feeds packets with in-order, shuffled, duplicate, stale and out-of-window
// sequence numbers and checks every result beat against a cycle-free window
// predictor. Several start sequence numbers are used, including both ends of
// the 32-bit range.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    localparam int WIN_LEN = 8;
    localparam int CLK_HALF = 6;
    localparam int SEQ_W = srrw_pkg::SEQ_W;
    localparam int PAY_W = srrw_pkg::PAY_W;
    localparam int LEN_W = srrw_pkg::LEN_W;
    localparam int KIND_W = srrw_pkg::KIND_W;

    typedef struct packed {
        logic [SEQ_W-1:0] seq;
        logic [PAY_W-1:0] pay;
        logic [LEN_W-1:0] len;
        logic             endf;
    } packet_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SEQ_W-1:0]  seq;
        logic [PAY_W-1:0]  pay;
        logic [LEN_W-1:0]  len;
        logic              endf;
        logic              last;
    } window_result_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [SEQ_W-1:0]              cfg_data = '0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [srrw_pkg::S_DATA_W-1:0] s_tdata = '0;    // seq_num, payload, payload_len
    logic                          s_tlast = 1'b0;  // end_flag
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [srrw_pkg::M_DATA_W-1:0] m_tdata;  // seq, payload_res, payload_len_res, end_seen
    logic [KIND_W-1:0]             m_tuser;  // kind
    logic                          m_tlast;  // last

    // Window copy kept by the predictor
    logic [SEQ_W-1:0] win_edge = '0;
    logic             win_marked  [WIN_LEN];
    logic [PAY_W-1:0] win_payload [WIN_LEN];
    logic [LEN_W-1:0] win_length  [WIN_LEN];

    packet_t        pending_pkts[$];
    window_result_t expected_results[$];
    packet_t        cur_pkt;

    int  tx_idle_pct = 24;
    int  rx_idle_pct = 49;
    logic tx_pause = 1'b0;
    logic rx_hold = 1'b0;
    logic rx_hold_req = 1'b0;

    int n_accepted = 0;
    int n_ack = 0;
    int n_deliver = 0;
    int n_ignore = 0;
    int n_cfg = 0;
    int mismatches = 0;

    selective_repeat_receive_window #(
        .WIN_LEN(WIN_LEN)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Clock
    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    // Compute the results one packet causes and advance the window copy
    function automatic void predict_window_results(packet_t p);
        window_result_t r;
        logic [SEQ_W:0] win_end;
        int slot;
        win_end = {1'b0, win_edge} + (SEQ_W+1)'(WIN_LEN);
        r = '0;
        r.seq = p.seq;
        r.endf = p.endf;
        if ({1'b0, p.seq} >= win_end) begin
            r.kind = srrw_pkg::KIND_IGNORE;
            expected_results.push_back(r);
        end else begin
            r.kind = srrw_pkg::KIND_ACK;
            expected_results.push_back(r);
            if (p.seq >= win_edge) begin
                slot = int'(p.seq % WIN_LEN);
                win_marked[slot] = 1'b1;
                win_payload[slot] = p.pay;
                win_length[slot] = p.len;
                // deliver the contiguous run from the edge
                while (win_marked[int'(win_edge % WIN_LEN)]) begin
                    slot = int'(win_edge % WIN_LEN);
                    r.kind = srrw_pkg::KIND_DELIVER;
                    r.seq = win_edge;
                    r.pay = win_payload[slot];
                    r.len = win_length[slot];
                    expected_results.push_back(r);
                    win_marked[slot] = 1'b0;
                    if (win_edge == '1)
                        break;
                    win_edge = win_edge + SEQ_W'(1);
                end
            end
        end
        r = expected_results.pop_back();
        r.last = 1'b1;
        expected_results.push_back(r);
    endfunction

    // Packet driver: hold a beat until accepted, then maybe load the next one
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_window_results(cur_pkt);
                n_accepted++;
            end
            if (!(s_tvalid && !s_tready)) begin
                if (pending_pkts.size() != 0 && !tx_pause &&
                    $urandom_range(99) >= tx_idle_pct) begin
                    cur_pkt = pending_pkts.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {5'b0, cur_pkt.len, cur_pkt.pay, cur_pkt.seq};
                    s_tlast <= cur_pkt.endf;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: check each beat against the oldest expectation
    always @(posedge aclk) begin : result_monitor
        window_result_t got;
        window_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.kind = m_tuser;
                got.seq = m_tdata[31:0];
                got.pay = m_tdata[63:32];
                got.len = m_tdata[74:64];
                got.endf = m_tdata[75];
                got.last = m_tlast;
                case (got.kind)
                    srrw_pkg::KIND_ACK:     n_ack++;
                    srrw_pkg::KIND_DELIVER: n_deliver++;
                    default:                n_ignore++;
                endcase
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result with nothing expected: kind %0d seq %h",
                                 $time, got.kind, got.seq);
                end else begin
                    want = expected_results.pop_front();
                    if (got.kind !== want.kind || got.seq !== want.seq ||
                        got.pay !== want.pay || got.len !== want.len ||
                        got.endf !== want.endf || got.last !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: mismatch exp kind %0d seq %h pay %h len %0d end %b last %b",
                                     $time, want.kind, want.seq, want.pay, want.len,
                                     want.endf, want.last);
                            $display("    got kind %0d seq %h pay %h len %0d end %b last %b",
                                     got.kind, got.seq, got.pay, got.len, got.endf, got.last);
                        end
                    end
                end
            end
            m_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Long receiver hold-off, counted here so the sender keeps pushing
    initial begin
        wait (rx_hold_req);
        @(posedge aclk);
        rx_hold <= 1'b1;
        repeat (200) @(posedge aclk);
        rx_hold <= 1'b0;
    end

    // Run limit
    initial begin
        #(64'd12 * 64'd300000);
        $display("timeout: %0d results still expected", expected_results.size());
        $display("FAIL");
        $finish;
    end

    task automatic add_pkt(logic [SEQ_W-1:0] seq, logic [PAY_W-1:0] pay,
                           logic [LEN_W-1:0] len, logic endf);
        packet_t p;
        p.seq = seq;
        p.pay = pay;
        p.len = len;
        p.endf = endf;
        pending_pkts.push_back(p);
    endtask

    task automatic add_random_pkt(logic [SEQ_W-1:0] seq);
        add_pkt(seq, $urandom, LEN_W'($urandom_range(0, 1024)), 1'($urandom_range(0, 1)));
    endtask

    // Wait until every packet is in and every result is out; sample between
    // edges so the driver's updates at the edge are already visible
    task automatic wait_drained();
        @(negedge aclk);
        while (pending_pkts.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(negedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // Write start_seq while the block is idle and reload the window copy
    task automatic write_start_seq(logic [SEQ_W-1:0] value);
        wait_drained();
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        win_edge = value;
        foreach (win_marked[i]) win_marked[i] = 1'b0;
        n_cfg++;
        cfg_valid <= 1'b0;
    endtask

    task automatic set_idling(int tx_pct, int rx_pct);
        @(posedge aclk);
        tx_idle_pct <= tx_pct;
        rx_idle_pct <= rx_pct;
    endtask

    // Queue shuffled runs of consecutive sequence numbers from the start
    // value, mixed with duplicates, stale and out-of-window packets
    task automatic queue_window_traffic(logic [SEQ_W-1:0] start, int count);
        logic [SEQ_W-1:0] base;
        logic [SEQ_W-1:0] run [WIN_LEN];
        logic [SEQ_W-1:0] tmp;
        logic [SEQ_W:0]   nxt;
        logic [SEQ_W:0]   room;
        int k;
        int j;
        int done;
        base = start;
        done = 0;
        while (done < count) begin
            room = 33'h1_0000_0000 - {1'b0, base};
            k = $urandom_range(1, WIN_LEN);
            if (room < k)
                k = int'(room);
            for (int i = 0; i < k; i++)
                run[i] = base + SEQ_W'(i);
            for (int i = k - 1; i > 0; i--) begin
                j = $urandom_range(0, i);
                tmp = run[i];
                run[i] = run[j];
                run[j] = tmp;
            end
            for (int i = 0; i < k; i++) begin
                if ($urandom_range(99) < 20) begin
                    case ($urandom_range(0, 2))
                        0: add_random_pkt(base - SEQ_W'($urandom_range(1, 40)));
                        1: begin
                            nxt = {1'b0, base} + (SEQ_W+1)'(WIN_LEN)
                                  + (SEQ_W+1)'($urandom_range(0, 100));
                            add_random_pkt(nxt[SEQ_W] ? $urandom : nxt[SEQ_W-1:0]);
                        end
                        default: add_random_pkt($urandom);
                    endcase
                end
                add_random_pkt(run[i]);
                if ($urandom_range(99) < 10)
                    add_random_pkt(run[i]);
            end
            done += k;
            nxt = {1'b0, base} + (SEQ_W+1)'(k);
            base = nxt[SEQ_W] ? '1 : nxt[SEQ_W-1:0];
        end
    endtask

    initial begin
        foreach (win_marked[i]) begin
            win_marked[i] = 1'b0;
            win_payload[i] = '0;
            win_length[i] = '0;
        end
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: duplicates, stale, beyond window, longest delivery run
        add_pkt(32'd1, 32'hFFFF_FFFF, 11'd1024, 1'b0);
        add_pkt(32'd1, 32'h0000_0000, 11'd0, 1'b1);
        add_pkt(32'd0, 32'h1234_5678, 11'd5, 1'b0);
        add_pkt(32'd0, 32'hDEAD_BEEF, 11'd7, 1'b1);
        add_pkt(32'd10, 32'hA5A5_A5A5, 11'd3, 1'b0);
        add_pkt(32'd9, 32'h5A5A_5A5A, 11'd1023, 1'b1);
        add_pkt(32'hFFFF_FFFF, 32'h0F0F_0F0F, 11'd512, 1'b1);
        for (int s = 8; s >= 3; s--)
            add_random_pkt(SEQ_W'(s));
        add_pkt(32'd2, 32'h8000_0001, 11'd1024, 1'b1);
        wait_drained();

        // Directed: top of the number range, edge saturation
        write_start_seq(32'hFFFF_FFF8);
        for (int s = 1; s < WIN_LEN; s++)
            add_random_pkt(32'hFFFF_FFF8 + SEQ_W'(s));
        add_random_pkt(32'hFFFF_FFF8);
        add_pkt(32'hFFFF_FFFF, 32'h7777_7777, 11'd1024, 1'b0);
        add_pkt(32'd0, 32'h0, 11'd0, 1'b1);

        // Random: sender idles less than receiver
        write_start_seq($urandom);
        queue_window_traffic(win_edge, 60);

        // Random: receiver idles less than sender, high start values
        write_start_seq(32'hFFFF_FFFF);
        set_idling(49, 24);
        queue_window_traffic(32'hFFFF_FFFF, 15);
        write_start_seq(32'hFFFF_FFF0);
        queue_window_traffic(32'hFFFF_FFF0, 25);

        // Random: no idling, one long receiver hold and one sender pause
        write_start_seq(32'd0);
        set_idling(0, 0);
        queue_window_traffic(32'd0, 60);
        rx_hold_req <= 1'b1;
        while (pending_pkts.size() > 40)
            @(posedge aclk);
        tx_pause <= 1'b1;
        @(posedge aclk);
        while (s_tvalid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);
        tx_pause <= 1'b0;

        wait_drained();
        repeat (20) @(posedge aclk);
        $display("Covered %0d packets over %0d start settings: %0d acks, %0d deliveries,",
                 n_accepted, n_cfg + 1, n_ack, n_deliver);
        $display("%0d ignored beyond window, %0d mismatches.", n_ignore, mismatches);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
